// ===== hdl/hcbe_pkg.sv =====
// Shared types, constants and symbol mapping functions for the Hill cipher block encoder.
`default_nettype none
package hcbe_pkg;

  // Alphabet and character mapping
  localparam int unsigned SYM_W       = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned MODULUS     = 27;
  localparam logic [7:0]  LETTER_BASE = 8'd64;
  localparam logic [7:0]  SPACE_CHAR  = 8'd32;

  // Key matrix registers
  localparam int unsigned KEY_N     = 4;
  localparam int unsigned KEY_W     = KEY_N * SYM_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW3 = 2'd3;
  localparam logic [KEY_W-1:0] KEY_ROW0_RST = 20'd518542;
  localparam logic [KEY_W-1:0] KEY_ROW1_RST = 20'd269320;
  localparam logic [KEY_W-1:0] KEY_ROW2_RST = 20'd250278;
  localparam logic [KEY_W-1:0] KEY_ROW3_RST = 20'd288327;

  // Block size default; the row sum width covers block sizes up to eight
  localparam int unsigned BLOCK_SIZE_DEF = 4;
  localparam int unsigned PROD_W         = 2 * SYM_W;
  localparam int unsigned SUM_W          = 13;

  // Row sum reduction: floor(s / 27) = (s * RECIP) >> RECIP_SH, exact for s < 10082
  localparam int unsigned RECIP_W  = 14;
  localparam logic [RECIP_W-1:0] RECIP = 14'd9710;
  localparam int unsigned RECIP_SH = 18;
  localparam int unsigned QP_W     = SUM_W + RECIP_W;
  localparam int unsigned Q_W      = QP_W - RECIP_SH;

  // Result queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_CW    = 3;
  localparam int unsigned BQ_DEPTH = 2;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } res_t;

  // Map a byte to its symbol: space is 0, else (b - 64) mod 27 as a proper residue
  function automatic sym_t char_to_sym(input char_t b);
    logic [8:0]  v;
    logic [13:0] p;
    logic [3:0]  q;
    logic [8:0]  r;
    v = {1'b0, b} + 9'd17;
    p = {5'b0, v} * 14'd19;
    q = p[12:9];
    r = v - ({5'b0, q} * 9'd27);
    return (b == SPACE_CHAR) ? '0 : r[SYM_W-1:0];
  endfunction

  // Map a symbol back to a character: 0 is space, else symbol plus 64
  function automatic char_t sym_to_char(input sym_t v);
    return (v == '0) ? SPACE_CHAR : ({3'b0, v} + LETTER_BASE);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hcbe_front.sv =====
// Front end: accepts characters, maps them to symbols and assembles column blocks.
`default_nettype none
module hcbe_front #(
  parameter int unsigned BLOCK_SIZE = hcbe_pkg::BLOCK_SIZE_DEF
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         push,
  output logic                                        full,
  input  wire  [hcbe_pkg::CHAR_W-1:0]                 in_char_in,
  input  wire                                         in_last_in,
  output logic                                        blk_push,
  output logic [BLOCK_SIZE-1:0][hcbe_pkg::SYM_W-1:0]  blk_data,
  input  wire                                         blk_full
);

  localparam int unsigned PW = $clog2(BLOCK_SIZE);

  logic [PW-1:0]                              pos_r, pos_nxt;
  logic [BLOCK_SIZE-1:0][hcbe_pkg::SYM_W-1:0] sym_r;
  hcbe_pkg::sym_t                             sym_new;
  logic                                       accept;
  logic                                       done;

  // Stall input only while the block queue is full
  assign full    = blk_full;
  assign accept  = push && !blk_full;
  assign sym_new = hcbe_pkg::char_to_sym(in_char_in);
  assign done    = in_last_in || (pos_r == PW'(BLOCK_SIZE - 1));
  assign blk_push = accept && done;

  // Build the outgoing column: collected entries, the new one, zero padding
  always_comb begin
    for (int c = 0; c < BLOCK_SIZE; c++) begin
      if (PW'(c) < pos_r) begin
        blk_data[c] = sym_r[c];
      end else if (PW'(c) == pos_r) begin
        blk_data[c] = sym_new;
      end else begin
        blk_data[c] = '0;
      end
    end
  end

  // Advance the fill position, wrap on block completion
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = done ? '0 : pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Hold collected symbols
  always_ff @(posedge clk) begin
    if (accept) begin
      sym_r[pos_r] <= sym_new;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hcbe_blkq.sv =====
// Short block queue that decouples the front end from the matrix unit.
`default_nettype none
module hcbe_blkq #(
  parameter int unsigned WIDTH = hcbe_pkg::BLOCK_SIZE_DEF * hcbe_pkg::SYM_W,
  parameter int unsigned DEPTH = hcbe_pkg::BQ_DEPTH
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_en,
  input  wire  [WIDTH-1:0] wr_data,
  output logic             full,
  input  wire              rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             wr;
  logic             rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr      = wr_en && !full;
  assign rd      = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (rd) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hcbe_back.sv =====
// Back end: key registers, row-by-row matrix multiply modulo 27 and result queue.
`default_nettype none
module hcbe_back #(
  parameter int unsigned BLOCK_SIZE = hcbe_pkg::BLOCK_SIZE_DEF
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         cfg_wr,
  input  wire  [hcbe_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  wire  [hcbe_pkg::KEY_W-1:0]                  cfg_data,
  input  wire                                         blk_empty,
  input  wire  [BLOCK_SIZE-1:0][hcbe_pkg::SYM_W-1:0]  blk_data,
  output logic                                        blk_pop,
  output logic                                        empty,
  input  wire                                         pop,
  output logic [hcbe_pkg::CHAR_W-1:0]                 out_char_out,
  output logic                                        out_last_out
);

  localparam int unsigned PW = $clog2(BLOCK_SIZE);

  // Key registers
  logic [hcbe_pkg::KEY_W-1:0] key_r [hcbe_pkg::KEY_N];
  logic [hcbe_pkg::KEY_W-1:0] key_nxt [hcbe_pkg::KEY_N];

  always_comb begin
    for (int i = 0; i < hcbe_pkg::KEY_N; i++) begin
      key_nxt[i] = key_r[i];
    end
    if (cfg_wr) begin
      case (cfg_index)
        hcbe_pkg::REG_KEY_ROW0: key_nxt[0] = cfg_data;
        hcbe_pkg::REG_KEY_ROW1: key_nxt[1] = cfg_data;
        hcbe_pkg::REG_KEY_ROW2: key_nxt[2] = cfg_data;
        hcbe_pkg::REG_KEY_ROW3: key_nxt[3] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= hcbe_pkg::KEY_ROW0_RST;
      key_r[1] <= hcbe_pkg::KEY_ROW1_RST;
      key_r[2] <= hcbe_pkg::KEY_ROW2_RST;
      key_r[3] <= hcbe_pkg::KEY_ROW3_RST;
    end else begin
      for (int i = 0; i < hcbe_pkg::KEY_N; i++) begin
        key_r[i] <= key_nxt[i];
      end
    end
  end

  // Full key matrix; positions beyond the 4x4 key act as identity
  logic [BLOCK_SIZE-1:0][BLOCK_SIZE-1:0][hcbe_pkg::SYM_W-1:0] kmat;

  for (genvar gr = 0; gr < BLOCK_SIZE; gr++) begin : g_row
    for (genvar gc = 0; gc < BLOCK_SIZE; gc++) begin : g_col
      if (gr < hcbe_pkg::KEY_N && gc < hcbe_pkg::KEY_N) begin : g_key
        assign kmat[gr][gc] = key_r[gr][gc*hcbe_pkg::SYM_W +: hcbe_pkg::SYM_W];
      end else begin : g_ident
        assign kmat[gr][gc] = (gr == gc) ? hcbe_pkg::SYM_W'(1) : '0;
      end
    end
  end

  // Result queue state
  hcbe_pkg::res_t               oq_mem_r [hcbe_pkg::OQ_DEPTH];
  logic [hcbe_pkg::OQ_AW-1:0]   oq_wp_r, oq_rp_r;
  logic [hcbe_pkg::OQ_CW-1:0]   oq_cnt_r, oq_cnt_nxt;
  logic                         oq_wr;
  logic                         oq_rd;
  hcbe_pkg::res_t               oq_wdata;

  // Pipeline state
  logic [PW-1:0]                row_r, row_nxt;
  logic                         issue;
  logic                         row_last;
  logic                         credit_ok;
  logic [hcbe_pkg::SUM_W-1:0]   sum_a;
  logic                         a_v_r;
  logic                         a_last_r;
  logic [hcbe_pkg::SUM_W-1:0]   a_sum_r;
  logic [hcbe_pkg::QP_W-1:0]    qp_b;
  logic                         b_v_r;
  logic                         b_last_r;
  logic [hcbe_pkg::SUM_W-1:0]   b_sum_r;
  logic [hcbe_pkg::Q_W-1:0]     b_q_r;
  logic [hcbe_pkg::SUM_W-1:0]   rem_c;

  // Issue a row only when the result queue has room for all rows in flight
  assign credit_ok = ({1'b0, oq_cnt_r} + {{hcbe_pkg::OQ_CW{1'b0}}, a_v_r}
                      + {{hcbe_pkg::OQ_CW{1'b0}}, b_v_r})
                     < (hcbe_pkg::OQ_CW + 1)'(hcbe_pkg::OQ_DEPTH);
  assign issue    = !blk_empty && credit_ok;
  assign row_last = (row_r == PW'(BLOCK_SIZE - 1));
  assign blk_pop  = issue && row_last;
  assign row_nxt  = issue ? (row_last ? '0 : row_r + PW'(1)) : row_r;

  // Stage A: dot product of one key row with the column
  always_comb begin
    logic [hcbe_pkg::PROD_W-1:0] prod;
    sum_a = '0;
    for (int c = 0; c < BLOCK_SIZE; c++) begin
      prod  = {{hcbe_pkg::SYM_W{1'b0}}, kmat[row_r][c]}
              * {{hcbe_pkg::SYM_W{1'b0}}, blk_data[c]};
      sum_a = sum_a + hcbe_pkg::SUM_W'(prod);
    end
  end

  // Stage B: quotient by reciprocal multiplication
  assign qp_b = {{hcbe_pkg::RECIP_W{1'b0}}, a_sum_r}
                * {{hcbe_pkg::SUM_W{1'b0}}, hcbe_pkg::RECIP};

  // Stage C: remainder, map to character and write the result queue
  assign rem_c    = b_sum_r - (hcbe_pkg::SUM_W'(b_q_r)
                               * hcbe_pkg::SUM_W'(hcbe_pkg::MODULUS));
  assign oq_wr    = b_v_r;
  assign oq_wdata = '{ch: hcbe_pkg::sym_to_char(rem_c[hcbe_pkg::SYM_W-1:0]),
                      last: b_last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      a_v_r <= issue;
      b_v_r <= a_v_r;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    a_sum_r  <= sum_a;
    a_last_r <= row_last;
    b_sum_r  <= a_sum_r;
    b_last_r <= a_last_r;
    b_q_r    <= qp_b[hcbe_pkg::QP_W-1:hcbe_pkg::RECIP_SH];
  end

  // Result queue
  assign empty        = (oq_cnt_r == '0);
  assign oq_rd        = pop && !empty;
  assign out_char_out = oq_mem_r[oq_rp_r].ch;
  assign out_last_out = oq_mem_r[oq_rp_r].last;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_wr && !oq_rd) begin
      oq_cnt_nxt = oq_cnt_r + hcbe_pkg::OQ_CW'(1);
    end else if (oq_rd && !oq_wr) begin
      oq_cnt_nxt = oq_cnt_r - hcbe_pkg::OQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_wr) begin
        oq_wp_r <= oq_wp_r + hcbe_pkg::OQ_AW'(1);
      end
      if (oq_rd) begin
        oq_rp_r <= oq_rp_r + hcbe_pkg::OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_mem_r[oq_wp_r] <= oq_wdata;
    end
  end

  // Checks
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= hcbe_pkg::OQ_CW'(hcbe_pkg::OQ_DEPTH))
    else $error("result queue occupancy out of range");

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_wr |-> (oq_cnt_r < hcbe_pkg::OQ_CW'(hcbe_pkg::OQ_DEPTH)) || oq_rd)
    else $error("result written into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    blk_pop |-> !blk_empty)
    else $error("block released from an empty queue");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && row_last) |=> (row_r == '0))
    else $error("row counter failed to wrap after last row");

endmodule
`default_nettype wire

// ===== hdl/hill_cipher_block_encoder.sv =====
// Top level of the Hill cipher block encoder: front end, block queue and matrix unit.
// Results pass via the block queue and the stage A and B registers to the result queue.
// Throughput: one character per cycle in unless the block queue is full, one ciphertext
// character per cycle out; a block yields BLOCK_SIZE rows, one per cycle while credit_ok.
// Reset (synchronous, active low) empties both queues, clears the partial block and loads
// the default key.
`default_nettype none
module hill_cipher_block_encoder #(
  parameter int unsigned BLOCK_SIZE = hcbe_pkg::BLOCK_SIZE_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             push,
  output logic                            full,
  input  wire  [hcbe_pkg::CHAR_W-1:0]     in_char_in,
  input  wire                             in_last_in,
  output logic                            empty,
  input  wire                             pop,
  output logic [hcbe_pkg::CHAR_W-1:0]     out_char_out,
  output logic                            out_last_out,
  input  wire                             valid,
  output logic                            ready,
  input  wire  [hcbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [hcbe_pkg::KEY_W-1:0]      cfg_data
);

  localparam int unsigned BW = BLOCK_SIZE * hcbe_pkg::SYM_W;

  logic [BLOCK_SIZE-1:0][hcbe_pkg::SYM_W-1:0] fe_data;
  logic [BLOCK_SIZE-1:0][hcbe_pkg::SYM_W-1:0] be_data;
  logic [BW-1:0]                              bq_rdata;
  logic                                       fe_push;
  logic                                       bq_full;
  logic                                       bq_empty;
  logic                                       be_pop;

  // Key writes are always taken
  assign ready   = 1'b1;
  assign be_data = bq_rdata;

  hcbe_front #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_char_in (in_char_in),
    .in_last_in (in_last_in),
    .blk_push   (fe_push),
    .blk_data   (fe_data),
    .blk_full   (bq_full)
  );

  hcbe_blkq #(
    .WIDTH (BW),
    .DEPTH (hcbe_pkg::BQ_DEPTH)
  ) u_blkq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_push),
    .wr_data (fe_data),
    .full    (bq_full),
    .rd_en   (be_pop),
    .rd_data (bq_rdata),
    .empty   (bq_empty)
  );

  hcbe_back #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (valid && ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .blk_empty    (bq_empty),
    .blk_data     (be_data),
    .blk_pop      (be_pop),
    .empty        (empty),
    .pop          (pop),
    .out_char_out (out_char_out),
    .out_last_out (out_last_out)
  );

endmodule
`default_nettype wire
